/* hw/rtl/sod_pkg.sv */
// Shared types and constants for the strike onset detector.
// Holds payload structs, queue item format, register map and the note table.
// No dependencies.
package sod_pkg;

    // Frame geometry and field widths
    localparam int CHANNELS    = 8;
    localparam int CH_BITS     = 3;
    localparam int SAMPLE_BITS = 10;
    localparam int VEL_BITS    = SAMPLE_BITS + 1;
    localparam int NOTE_BITS   = 6;
    localparam int THR_BITS    = 10;
    localparam int REB_BITS    = 11;

    // Decoupling queue geometry
    localparam int QADDR_BITS = 2;
    localparam int QDEPTH     = 1 << QADDR_BITS;

    // Register reset values
    localparam logic [THR_BITS-1:0] STRIKE_RESET  = 10'd10;
    localparam logic [REB_BITS-1:0] REBOUND_RESET = 11'h7FD;

    // Register map, one word per register
    typedef enum logic {
        REG_STRIKE  = 1'b0,
        REG_REBOUND = 1'b1
    } reg_idx_t;

    // Scale notes, indexed by channel modulo 16
    localparam logic [NOTE_BITS-1:0] NOTE_TABLE [16] = '{
        6'd0,  6'd2,  6'd4,  6'd7,  6'd9,  6'd12, 6'd14, 6'd16,
        6'd19, 6'd21, 6'd24, 6'd26, 6'd28, 6'd31, 6'd33, 6'd36
    };

    typedef struct packed {
        logic [CH_BITS-1:0]     channel;
        logic [SAMPLE_BITS-1:0] sample;
    } in_t;

    typedef struct packed {
        logic signed [VEL_BITS-1:0] velocity;
        logic                       hit;
        logic [NOTE_BITS-1:0]       note;
        logic [SAMPLE_BITS-1:0]     strength;
    } out_t;

    // Classified transaction as it travels from front to back
    typedef struct packed {
        logic                   in_range;
        logic                   last;
        logic [CH_BITS-1:0]     channel;
        logic [SAMPLE_BITS-1:0] sample;
    } q_item_t;

    typedef struct packed {
        logic [THR_BITS-1:0] strike_threshold;
        logic [REB_BITS-1:0] rebound_threshold;
    } cfg_t;

    typedef struct packed {
        logic                  push;
        logic                  pop;
        logic [QADDR_BITS:0]   count;
    } q_status_t;

    function automatic logic [NOTE_BITS-1:0] note_of(input logic [CH_BITS-1:0] ch);
        logic [3:0] idx;
        idx = 4'(ch);
        return NOTE_TABLE[idx];
    endfunction

endpackage

/* hw/rtl/sod_front.sv */
// Front stage of the strike onset detector: accepts input transactions and
// classifies them (channel range, frame close). Depends on sod_pkg.
module sod_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sod_pkg::in_t      s_data,
    output logic              f_valid,
    input  logic              f_ready,
    output sod_pkg::q_item_t  f_item
);

    logic              valid_reg;
    sod_pkg::q_item_t  item_reg;
    sod_pkg::q_item_t  item_next;

    // Take a new transaction whenever the stage is empty or drains this cycle
    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_item  = item_reg;

    // Classify the incoming sample
    always_comb begin
        item_next.in_range = ({1'b0, s_data.channel} < (sod_pkg::CH_BITS + 1)'(sod_pkg::CHANNELS));
        item_next.last     = (s_data.channel == sod_pkg::CH_BITS'(sod_pkg::CHANNELS - 1));
        item_next.channel  = s_data.channel;
        item_next.sample   = s_data.sample;
    end

    // Hold or advance the stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (f_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

/* hw/rtl/sod_queue.sv */
// Short queue between the front and back stages of the strike onset detector.
// Depends on sod_pkg for the item type and depth.
module sod_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sod_pkg::q_item_t    in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output sod_pkg::q_item_t    out_item,
    output sod_pkg::q_status_t  status
);

    sod_pkg::q_item_t                mem_reg [sod_pkg::QDEPTH];
    logic [sod_pkg::QADDR_BITS-1:0]  wr_ptr_reg;
    logic [sod_pkg::QADDR_BITS-1:0]  rd_ptr_reg;
    logic [sod_pkg::QADDR_BITS:0]    count_reg;
    logic                            push;
    logic                            pop;

    assign in_ready  = (count_reg != (sod_pkg::QADDR_BITS + 1)'(sod_pkg::QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    assign status.push  = push;
    assign status.pop   = pop;
    assign status.count = count_reg;

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the entry
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* hw/rtl/sod_back.sv */
// Back stage of the strike onset detector: velocity, strike tracking, hit
// confirmation and the output register. Depends on sod_pkg.
module sod_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  sod_pkg::cfg_t     cfg,
    input  logic              q_valid,
    output logic              q_pop,
    input  sod_pkg::q_item_t  q_item,
    output logic              m_valid,
    input  logic              m_ready,
    output sod_pkg::out_t     m_data
);

    localparam int SB = sod_pkg::SAMPLE_BITS;
    localparam int VB = sod_pkg::VEL_BITS;
    localparam int CB = sod_pkg::CH_BITS;

    logic [SB-1:0]  prev_frame_reg [sod_pkg::CHANNELS];
    logic [CB-1:0]  best_ch_reg,   best_ch_next;
    logic           best_vld_reg,  best_vld_next;
    logic [SB-1:0]  best_drop_reg, best_drop_next;
    logic [CB-1:0]  pend_ch_reg,   pend_ch_next;
    logic           pend_vld_reg,  pend_vld_next;
    logic [SB-1:0]  pend_drop_reg, pend_drop_next;
    logic           out_vld_reg;
    sod_pkg::out_t  out_reg,       out_next;

    logic [SB-1:0]        prev;
    logic signed [VB-1:0] vel;
    logic signed [VB-1:0] drop;
    logic                 hit;
    logic                 strike;

    // Pop whenever the output register is free or being drained
    assign q_pop   = q_valid && (!out_vld_reg || m_ready);
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // Velocity, hit check and candidate tracking
    always_comb begin
        prev   = prev_frame_reg[q_item.channel];
        vel    = $signed({1'b0, q_item.sample}) - $signed({1'b0, prev});
        drop   = $signed({1'b0, prev}) - $signed({1'b0, q_item.sample});
        hit    = pend_vld_reg && (pend_ch_reg == q_item.channel)
                 && (drop < $signed(cfg.rebound_threshold));
        strike = (drop > $signed({1'b0, cfg.strike_threshold})) && (drop > 0)
                 && (!best_vld_reg || (drop > $signed({1'b0, best_drop_reg})));

        best_ch_next   = best_ch_reg;
        best_vld_next  = best_vld_reg;
        best_drop_next = best_drop_reg;
        pend_ch_next   = pend_ch_reg;
        pend_vld_next  = pend_vld_reg;
        pend_drop_next = pend_drop_reg;
        out_next       = '0;

        if (q_item.in_range) begin
            if (strike) begin
                best_vld_next  = 1'b1;
                best_ch_next   = q_item.channel;
                best_drop_next = drop[SB-1:0];
            end
            // Hand the frame's candidate over at frame close
            if (q_item.last) begin
                pend_vld_next  = best_vld_next;
                pend_ch_next   = best_vld_next ? best_ch_next : '0;
                pend_drop_next = best_vld_next ? best_drop_next : '0;
                best_vld_next  = 1'b0;
                best_ch_next   = '0;
                best_drop_next = '0;
            end
            out_next.velocity = vel;
            out_next.hit      = hit;
            out_next.note     = hit ? sod_pkg::note_of(q_item.channel) : '0;
            out_next.strength = hit ? pend_drop_reg : '0;
        end
    end

    // Update tracking state on each popped transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < sod_pkg::CHANNELS; i++) begin
                prev_frame_reg[i] <= '0;
            end
            best_ch_reg   <= '0;
            best_vld_reg  <= 1'b0;
            best_drop_reg <= '0;
            pend_ch_reg   <= '0;
            pend_vld_reg  <= 1'b0;
            pend_drop_reg <= '0;
        end else if (q_pop) begin
            if (q_item.in_range) begin
                prev_frame_reg[q_item.channel] <= q_item.sample;
            end
            best_ch_reg   <= best_ch_next;
            best_vld_reg  <= best_vld_next;
            best_drop_reg <= best_drop_next;
            pend_ch_reg   <= pend_ch_next;
            pend_vld_reg  <= pend_vld_next;
            pend_drop_reg <= pend_drop_next;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (q_pop) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= out_next;
        end
    end

endmodule

/* hw/rtl/strike_onset_detector.sv */
// Strike onset detector top level: register port, front, queue and back stages.
// Depends on sod_pkg, sod_front, sod_queue and sod_back.
//
// Pad samples come in one transaction per channel, channels 0 to 7 in order,
// channel 7 closing a frame; each accepted transaction yields exactly one
// result transaction with the velocity against the previous frame and, when a
// strike recorded in the last frame rebounds, a hit with its note and
// strength. The block takes one transaction per clock cycle when the result
// side keeps up. An accepted transaction passes from the front register into
// the four-entry queue, and the back stage pops it from there into its output
// register, updating all tracking state on that pop.
// Thresholds are written over the register port (strike at 0x0, rebound at
// 0x4); the user must write them only while no transaction is in flight, as
// the block itself does not enforce this.
module strike_onset_detector (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  sod_pkg::in_t        s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sod_pkg::out_t       m_data
);

    logic [sod_pkg::THR_BITS-1:0] strike_reg;
    logic [sod_pkg::REB_BITS-1:0] rebound_reg;
    sod_pkg::reg_idx_t            reg_idx;
    sod_pkg::cfg_t                cfg;
    logic                         f_valid;
    logic                         f_ready;
    sod_pkg::q_item_t             f_item;
    logic                         q_valid;
    logic                         q_pop;
    sod_pkg::q_item_t             q_item;
    sod_pkg::q_status_t           q_status;

    assign pready  = 1'b1;
    assign reg_idx = sod_pkg::reg_idx_t'(paddr[2]);
    assign cfg.strike_threshold  = strike_reg;
    assign cfg.rebound_threshold = rebound_reg;

    // Write configuration registers on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strike_reg  <= sod_pkg::STRIKE_RESET;
            rebound_reg <= sod_pkg::REBOUND_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                sod_pkg::REG_STRIKE:  strike_reg  <= pwdata[sod_pkg::THR_BITS-1:0];
                sod_pkg::REG_REBOUND: rebound_reg <= pwdata[sod_pkg::REB_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (reg_idx)
            sod_pkg::REG_STRIKE:  prdata = 32'(strike_reg);
            sod_pkg::REG_REBOUND: prdata = 32'(rebound_reg);
            default:              prdata = '0;
        endcase
    end

    sod_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .f_valid (f_valid),
        .f_ready (f_ready),
        .f_item  (f_item)
    );

    sod_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_pop),
        .out_item  (q_item),
        .status    (q_status)
    );

    sod_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTH
    // Queue occupancy never exceeds its depth
    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.count <= (sod_pkg::QADDR_BITS + 1)'(sod_pkg::QDEPTH))
        else $error("queue occupancy above depth");

    // An accepted input transaction is held by the front stage next cycle
    a_front_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> f_valid)
        else $error("accepted transaction lost at front stage");

    // The back stage only pops a non-empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.pop |-> (q_status.count != '0))
        else $error("pop from empty queue");

    // Occupancy advances by one on a push without a pop
    a_q_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_status.push && !q_status.pop) |=> (q_status.count == $past(q_status.count) + 1'b1))
        else $error("queue count did not advance on push");
`endif

endmodule

/* tb/sv/strike_onset_detector_tb.sv */
// Self-checking testbench for strike_onset_detector: drives pad sample frames and
// threshold writes, predicts velocity and hit results, checks every result transaction.
// Depends on sod_pkg and the strike_onset_detector RTL.
module strike_onset_detector_tb;

    localparam int LIMIT_TIME   = 2_000_000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int MAX_LEVEL    = (1 << sod_pkg::SAMPLE_BITS) - 1;

    // Scale note of each pad channel
    localparam logic [sod_pkg::NOTE_BITS-1:0] PAD_NOTE [8] = '{
        6'd0, 6'd2, 6'd4, 6'd7, 6'd9, 6'd12, 6'd14, 6'd16
    };

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;
    logic           s_valid;
    logic           s_ready;
    sod_pkg::in_t   s_data;
    logic           m_valid;
    logic           m_ready;
    sod_pkg::out_t  m_data;

    // Pending result transactions, oldest first
    sod_pkg::out_t pad_results_q[$];
    int   mismatches = 0;
    int   items_sent = 0;

    // Traffic shaping knobs
    bit   tx_steady   = 1'b0;
    bit   rx_steady   = 1'b0;
    int   hold_cycles = 0;
    int   burst_left  = 0;

    // Shadow of the detector state and thresholds
    logic [sod_pkg::SAMPLE_BITS-1:0]   last_level [sod_pkg::CHANNELS];
    logic [sod_pkg::CH_BITS-1:0]       cand_ch;
    logic                              cand_ok;
    logic [sod_pkg::SAMPLE_BITS-1:0]   cand_drop;
    logic [sod_pkg::CH_BITS-1:0]       armed_ch;
    logic                              armed_ok;
    logic [sod_pkg::SAMPLE_BITS-1:0]   armed_drop;
    logic [sod_pkg::THR_BITS-1:0]      strike_thr;
    logic signed [sod_pkg::REB_BITS-1:0] rebound_thr;

    strike_onset_detector dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Compute the result of one sample and advance the shadow state
    function automatic sod_pkg::out_t strike_response(input sod_pkg::in_t item);
        int   cur;
        int   prv;
        int   drop;
        sod_pkg::out_t r;
        r    = '0;
        cur  = item.sample;
        prv  = last_level[item.channel];
        drop = prv - cur;
        r.velocity = sod_pkg::VEL_BITS'(cur - prv);
        // Confirm the armed strike when its channel rebounds
        if (armed_ok && armed_ch == item.channel && drop < int'(rebound_thr)) begin
            r.hit      = 1'b1;
            r.note     = PAD_NOTE[item.channel];
            r.strength = armed_drop;
        end
        // Track the largest drop of this frame; ties keep the earlier channel
        if (drop > int'(strike_thr) && drop > 0 && (!cand_ok || drop > int'(cand_drop))) begin
            cand_ok   = 1'b1;
            cand_ch   = item.channel;
            cand_drop = sod_pkg::SAMPLE_BITS'(drop);
        end
        last_level[item.channel] = item.sample;
        // Frame close: arm the candidate for the next frame
        if (item.channel == sod_pkg::CH_BITS'(sod_pkg::CHANNELS - 1)) begin
            armed_ok   = cand_ok;
            armed_ch   = cand_ok ? cand_ch : '0;
            armed_drop = cand_ok ? cand_drop : '0;
            cand_ok    = 1'b0;
            cand_ch    = '0;
            cand_drop  = '0;
        end
        return r;
    endfunction

    // Send one sample transaction, with burst gaps on the sender side
    task automatic send_sample(input int ch, input int smp);
        sod_pkg::in_t item;
        item.channel = sod_pkg::CH_BITS'(ch);
        item.sample  = sod_pkg::SAMPLE_BITS'(smp);
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!tx_steady) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        pad_results_q.push_back(strike_response(item));
        items_sent++;
    endtask

    // Stop offering and wait until every result has come back
    task automatic drain_results;
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (pad_results_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input sod_pkg::reg_idx_t idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            sod_pkg::REG_STRIKE:  strike_thr  = value[sod_pkg::THR_BITS-1:0];
            sod_pkg::REG_REBOUND: rebound_thr = value[sod_pkg::REB_BITS-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_thresholds(input int strike, input int rebound);
        drain_results();
        write_register(sod_pkg::REG_STRIKE, 32'(strike) & 32'h3FF);
        write_register(sod_pkg::REG_REBOUND, 32'(rebound) & 32'h7FF);
    endtask

    // One frame of channels first_ch..7 with random strikes, ties and rebounds
    task automatic send_frame(input int first_ch);
        int level;
        int pick;
        int strike_ch;
        int tie_ch;
        int depth;
        int val;
        strike_ch = ($urandom_range(0, 9) < 7) ? $urandom_range(0, sod_pkg::CHANNELS - 1) : -1;
        tie_ch    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, sod_pkg::CHANNELS - 1) : -1;
        depth     = $urandom_range(0, 400);
        for (int ch = first_ch; ch < sod_pkg::CHANNELS; ch++) begin
            level = last_level[ch];
            pick  = $urandom_range(0, 99);
            if (armed_ok && ch == armed_ch && pick < 75) begin
                val = $urandom_range(level, MAX_LEVEL);
            end else if (ch == strike_ch || ch == tie_ch) begin
                val = (level >= depth) ? level - depth : $urandom_range(0, level);
            end else if (pick < 15) begin
                val = $urandom_range(0, MAX_LEVEL);
            end else if (pick < 35) begin
                val = $urandom_range(600, MAX_LEVEL);
            end else begin
                val = level + $urandom_range(0, 16) - 8;
            end
            if (val < 0) val = 0;
            if (val > MAX_LEVEL) val = MAX_LEVEL;
            send_sample(ch, val);
        end
    endtask

    task automatic test_directed_frames;
        // Full scale rise on every channel
        for (int ch = 0; ch < sod_pkg::CHANNELS; ch++) send_sample(ch, MAX_LEVEL);
        // Equal drops on channels 1 and 5: channel 1 stays the candidate
        send_sample(0, 1023); send_sample(1, 523); send_sample(2, 1023); send_sample(3, 1023);
        send_sample(4, 1023); send_sample(5, 523); send_sample(6, 1023); send_sample(7, 1023);
        // Rebound on 1 hits; full drops on 0 and 7 tie, channel 0 is armed
        send_sample(0, 0);    send_sample(1, 1023); send_sample(2, 1023); send_sample(3, 1023);
        send_sample(4, 1023); send_sample(5, 1023); send_sample(6, 1023); send_sample(7, 0);
        // Channel 0 rebound hits with full strength
        send_sample(0, 600);
    endtask

    task automatic test_threshold_extremes;
        int strike_set [6]  = '{0, 1023, 0, 1023, 512, 10};
        int rebound_set [6] = '{-1023, 1023, 1023, -1023, -1024, -3};
        for (int k = 0; k < 6; k++) begin
            set_thresholds(strike_set[k], rebound_set[k]);
            tx_steady = (k == 2);
            rx_steady = (k == 2);
            repeat (4) send_frame(0);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_output_backpressure;
        drain_results();
        // Receiver holds off while the sender keeps offering
        hold_cycles = 400;
        tx_steady   = 1'b1;
        repeat (8) send_frame(0);
        tx_steady   = 1'b0;
        drain_results();
    endtask

    task automatic test_random_traffic;
        int target;
        int pick;
        int tmp;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            // New thresholds between segments, mostly in a useful range
            if ($urandom_range(0, 9) < 3) begin
                set_thresholds($urandom_range(0, 1023), $urandom_range(0, 2047));
            end else begin
                tmp = $urandom_range(0, 80);
                set_thresholds($urandom_range(0, 120), 20 - tmp);
            end
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            repeat (25) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    send_frame(0);
                end else if (pick < 90) begin
                    send_frame($urandom_range(1, sod_pkg::CHANNELS - 1));
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_sample($urandom_range(0, sod_pkg::CHANNELS - 1),
                                    $urandom_range(0, MAX_LEVEL));
                end
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Receiver: long hold when asked, else steady or random runs of ready
    initial begin
        bit rx_on;
        int run_left;
        rx_on    = 1'b1;
        run_left = 0;
        m_ready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else if (rx_steady) begin
                m_ready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    rx_on    = !rx_on;
                    run_left = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 5);
                end
                run_left--;
                m_ready <= rx_on;
            end
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge aclk) begin
        sod_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pad_results_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual vel=%0d hit=%0b %s",
                         $time, m_data.velocity, m_data.hit,
                         $sformatf("note=%0d str=%0d", m_data.note, m_data.strength));
            end else begin
                want = pad_results_q.pop_front();
                if (m_data.velocity !== want.velocity || m_data.hit !== want.hit ||
                    m_data.note !== want.note || m_data.strength !== want.strength) begin
                    mismatches++;
                    $display("%0t: expected vel=%0d hit=%0b note=%0d str=%0d, %s",
                             $time, want.velocity, want.hit, want.note, want.strength,
                             $sformatf("actual vel=%0d hit=%0b note=%0d str=%0d",
                                       m_data.velocity, m_data.hit, m_data.note,
                                       m_data.strength));
                end
            end
        end
    end

    initial begin
        #LIMIT_TIME;
        $display("[strike_onset_detector] ERROR");
        $finish;
    end

    initial begin
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        s_valid <= 1'b0;
        s_data  <= '0;
        for (int ch = 0; ch < sod_pkg::CHANNELS; ch++) last_level[ch] = '0;
        cand_ch     = '0;
        cand_ok     = 1'b0;
        cand_drop   = '0;
        armed_ch    = '0;
        armed_ok    = 1'b0;
        armed_drop  = '0;
        strike_thr  = sod_pkg::STRIKE_RESET;
        rebound_thr = sod_pkg::REBOUND_RESET;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_frames();
        test_threshold_extremes();
        test_output_backpressure();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pad_results_q.size() == 0) begin
            $display("[strike_onset_detector] OK");
        end else begin
            $display("[strike_onset_detector] ERROR");
        end
        $finish;
    end

endmodule

/* strike_onset_detector.f */
hw/rtl/sod_pkg.sv
hw/rtl/sod_front.sv
hw/rtl/sod_queue.sv
hw/rtl/sod_back.sv
hw/rtl/strike_onset_detector.sv
tb/sv/strike_onset_detector_tb.sv
